// ===== hdl/pwlsd_pkg.sv =====
// shared types, constants and helper functions of the line sensor decoder
package pwlsd_pkg;

  localparam int unsigned PulseWidthW = 9;
  localparam int unsigned CfgW        = 8;
  localparam int unsigned PatternW    = 6;
  localparam int unsigned FrameLen    = 16;
  localparam int unsigned CountW      = 5;
  localparam int unsigned InDataW     = 16;
  localparam int unsigned OutDataW    = 24;

  localparam logic [PulseWidthW-1:0] PULSE_SATURATION = 9'd255;
  localparam logic [CountW-1:0]      FRAME_LAST_IDX   = 5'd15;
  localparam logic [CountW-1:0]      FRAME_IDLE_CNT   = 5'd16;

  localparam logic [CfgW-1:0] SHORT_MIN_RST = 8'd50;
  localparam logic [CfgW-1:0] SHORT_MAX_RST = 8'd100;
  localparam logic [CfgW-1:0] OFF_LINE_RST  = 8'd127;

  localparam logic [PatternW-1:0] PAT_CAN_RIGHT = 6'd60;
  localparam logic [PatternW-1:0] PAT_CAN_LEFT  = 6'd15;
  localparam logic [PatternW-1:0] PAT_BOTH      = 6'd63;

  typedef enum logic [1:0] {
    CFG_SHORT_MIN = 2'd0,
    CFG_SHORT_MAX = 2'd1,
    CFG_OFF_LINE  = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIR_FORWARD   = 2'd0,
    DIR_CAN_RIGHT = 2'd1,
    DIR_CAN_LEFT  = 2'd2,
    DIR_BOTH      = 2'd3
  } dir_e;

  typedef struct packed {
    logic take;
    logic eval;
  } dp_cmd_t;

  typedef struct packed {
    logic frame_last;
  } dp_sts_t;

  function automatic logic [2:0] pop6(input logic [PatternW-1:0] p);
    logic [2:0] n;
    n = 3'd0;
    for (int k = 0; k < PatternW; k++) begin
      n = n + {2'b00, p[k]};
    end
    return n;
  endfunction

  function automatic logic [2:0] tz6(input logic [PatternW-1:0] p);
    logic [2:0] n;
    n = 3'd0;
    for (int k = PatternW - 1; k >= 0; k--) begin
      if (p[k]) begin
        n = 3'(k);
      end
    end
    return n;
  endfunction

  function automatic logic run6(input logic [PatternW-1:0] p);
    logic [PatternW-1:0] v;
    logic [PatternW-1:0] v1;
    v  = p >> tz6(p);
    v1 = v + 6'd1;
    return (p != '0) && ((v & v1) == '0);
  endfunction

  // average of weights -30+12k over a contiguous run is exact
  function automatic logic [7:0] run_pos(input logic [PatternW-1:0] p);
    logic [7:0] s12;
    logic [7:0] l6;
    s12 = {5'd0, tz6(p)} * 8'd12;
    l6  = {5'd0, pop6(p)} * 8'd6;
    return s12 + l6 - 8'd36;
  endfunction

  function automatic dir_e steer(input logic [PatternW-1:0] p);
    dir_e d;
    priority if (p == PAT_CAN_RIGHT) d = DIR_CAN_RIGHT;
    else if (p == PAT_CAN_LEFT)      d = DIR_CAN_LEFT;
    else if (p == PAT_BOTH)          d = DIR_BOTH;
    else                             d = DIR_FORWARD;
    return d;
  endfunction

endpackage

// ===== hdl/pulse_width_line_sensor_decoder_unit.sv =====
// top level of the pulse width line sensor decoder
// one pulse item is taken per cycle, except in the evaluation step after a 16th pulse
// that step registers the result item once the output is free; it is held until taken
// while a result waits, the next frame's pulses are still taken until its own 16th pulse
// reset clears the frame (no frame active), the stored pattern to 0 and position to 127
// registers reset to 50, 100 and 127
module pulse_width_line_sensor_decoder_unit import pwlsd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // pulse_width[8:0], zero fill
  input  logic                s_axis_tuser,   // frame_start
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // reading_valid, timed_out, checksum_ok, pattern[5:0], position[7:0],
  // direction[1:0], zero fill
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_wdata_i
);

  logic [CfgW-1:0] short_min_q;
  logic [CfgW-1:0] short_max_q;
  logic [CfgW-1:0] off_line_q;
  dp_cmd_t         cmd;
  dp_sts_t         sts;
  cfg_idx_e        cfg_idx;

  assign cfg_idx = cfg_idx_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_min_q <= SHORT_MIN_RST;
      short_max_q <= SHORT_MAX_RST;
      off_line_q  <= OFF_LINE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx)
        CFG_SHORT_MIN: short_min_q <= cfg_wdata_i;
        CFG_SHORT_MAX: short_max_q <= cfg_wdata_i;
        CFG_OFF_LINE:  off_line_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  pwlsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pwlsd_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .pulse_width_i (s_axis_tdata[PulseWidthW-1:0]),
    .frame_start_i (s_axis_tuser),
    .short_min_i   (short_min_q),
    .short_max_i   (short_max_q),
    .off_line_i    (off_line_q),
    .out_data_o    (m_axis_tdata)
  );

  a_valid_reading_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (!m_axis_tdata[1] && m_axis_tdata[2]))
    else $error("valid reading with timeout or bad checksum");

  a_result_after_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result raised outside evaluation step");

  a_stall_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid))
    else $error("input stalled without a taken item");

endmodule

// ===== hdl/pwlsd_ctrl.sv =====
// frame controller: input handshake, evaluation step and output valid
module pwlsd_ctrl import pwlsd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,
    ST_EVAL = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_RUN: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
        if (in_valid_i && sts_i.frame_last) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          cmd_o.eval  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/pwlsd_dp.sv =====
// datapath: bit collection, frame check, stored reading and result register
module pwlsd_dp import pwlsd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dp_cmd_t                cmd_i,
  output dp_sts_t                sts_o,
  input  logic [PulseWidthW-1:0] pulse_width_i,
  input  logic                   frame_start_i,
  input  logic [CfgW-1:0]        short_min_i,
  input  logic [CfgW-1:0]        short_max_i,
  input  logic [CfgW-1:0]        off_line_i,
  output logic [OutDataW-1:0]    out_data_o
);

  logic [CountW-1:0]      count_q, count_d;
  logic [FrameLen-1:0]    bits_q, bits_d;
  logic                   tout_q, tout_d;
  logic [PatternW-1:0]    pat_q, pat_d;
  logic [7:0]             pos_q, pos_d;
  logic [OutDataW-1:0]    out_q;

  logic                   sat;
  logic [PulseWidthW-1:0] wc;
  logic                   bit_v;
  logic [PatternW-1:0]    first;
  logic                   match;
  logic                   ok;

  assign sat   = (pulse_width_i == '0) || (pulse_width_i >= PULSE_SATURATION);
  assign wc    = sat ? PULSE_SATURATION : pulse_width_i;
  assign bit_v = !((wc > {1'b0, short_min_i}) && (wc < {1'b0, short_max_i}));

  assign sts_o.frame_last = !frame_start_i && (count_q == FRAME_LAST_IDX);

  // the top two bits of byte two are don't care
  assign first = bits_q[13:8];
  assign match = (bits_q[5:0] == ~first);
  assign ok    = !tout_q && match;

  always_comb begin
    count_d = count_q;
    bits_d  = bits_q;
    tout_d  = tout_q;
    if (cmd_i.take) begin
      if (frame_start_i) begin
        count_d = 5'd1;
        bits_d  = {{(FrameLen-1){1'b0}}, bit_v};
        tout_d  = sat;
      end else if (count_q < FRAME_IDLE_CNT) begin
        count_d = count_q + 5'd1;
        bits_d  = {bits_q[FrameLen-2:0], bit_v};
        tout_d  = tout_q || sat;
      end
    end
  end

  always_comb begin
    pat_d = pat_q;
    pos_d = pos_q;
    if (cmd_i.eval && ok) begin
      pat_d = first;
      pos_d = run6(first) ? run_pos(first) : off_line_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= FRAME_IDLE_CNT;
      bits_q  <= '0;
      tout_q  <= 1'b0;
      pat_q   <= '0;
      pos_q   <= OFF_LINE_RST;
    end else begin
      count_q <= count_d;
      bits_q  <= bits_d;
      tout_q  <= tout_d;
      pat_q   <= pat_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      out_q <= {5'd0, steer(pat_d), pos_d, pat_d, match, tout_q, ok};
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== tb/pulse_width_line_sensor_decoder_unit_test.sv =====
// self-checking testbench of the pulse width line sensor decoder
module pulse_width_line_sensor_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pwlsd_pkg::*;

  localparam int QuietLimit = 5000;
  localparam int IdleTail   = 8;
  localparam int RandomItems = 150;

  typedef struct {
    logic                       rd_valid;
    logic                       timed_out;
    logic                       sum_ok;
    logic [PatternW-1:0]        pattern;
    logic signed [7:0]          position;
    dir_e                       direction;
  } reading_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // pulse_width[8:0], zero fill
  logic                s_axis_tuser = 1'b0; // frame_start
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // reading_valid, timed_out, checksum_ok, pattern[5:0], position[7:0],
  // direction[1:0], zero fill
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_idx_i = '0;
  logic [CfgW-1:0]     cfg_wdata_i = '0;

  // decoder state as predicted
  logic [CfgW-1:0]     cfg_short_min = SHORT_MIN_RST;
  logic [CfgW-1:0]     cfg_short_max = SHORT_MAX_RST;
  logic [CfgW-1:0]     cfg_off_line  = OFF_LINE_RST;
  int unsigned         pulse_idx = FrameLen;
  logic [FrameLen-1:0] shift_bits = '0;
  logic                frame_timed_out = 1'b0;
  logic [PatternW-1:0] kept_pattern = '0;
  logic [7:0]          kept_position = OFF_LINE_RST;

  reading_t expected_readings[$];
  int error_count = 0;
  int decoded_pulses = 0;
  int readings_checked = 0;
  int settings_used = 1;
  int burst_left = 0;
  int quiet_cycles = 0;
  int rx_tick = 0;
  int rx_mode = 0;

  pulse_width_line_sensor_decoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicts the decoder for one accepted pulse item
  task automatic track_pulse(input logic [PulseWidthW-1:0] w, input logic st);
    logic [PulseWidthW-1:0] wc;
    logic                   b;
    logic [PatternW-1:0]    first;
    logic [7:0]             second;
    logic                   sum_ok;
    logic [PatternW-1:0]    run;
    int                     ones;
    int                     total;
    reading_t               r;
    if (st) begin
      pulse_idx = 0;
      shift_bits = '0;
      frame_timed_out = 1'b0;
    end else if (pulse_idx >= FrameLen) begin
      return;
    end
    decoded_pulses++;
    wc = w;
    if (wc == '0 || wc >= PULSE_SATURATION) begin
      wc = PULSE_SATURATION;
      frame_timed_out = 1'b1;
    end
    b = (wc > {1'b0, cfg_short_min} && wc < {1'b0, cfg_short_max}) ? 1'b0 : 1'b1;
    shift_bits = {shift_bits[FrameLen-2:0], b};
    pulse_idx++;
    if (pulse_idx < FrameLen) return;
    first = shift_bits[13:8];
    second = shift_bits[7:0] | 8'hC0;
    sum_ok = (second == ~{2'b00, first});
    if (!frame_timed_out && sum_ok) begin
      kept_pattern = first;
      ones = 0;
      total = 0;
      for (int k = 0; k < PatternW; k++) begin
        if (first[k]) begin
          ones++;
          total += -30 + 12 * k;
        end
      end
      run = first;
      if (run != '0) begin
        while (!run[0]) run = run >> 1;
      end
      if (ones > 0 && (run & (run + 1)) == 0) begin
        kept_position = 8'(total / ones);
      end else begin
        kept_position = cfg_off_line;
      end
    end
    r.rd_valid  = !frame_timed_out && sum_ok;
    r.timed_out = frame_timed_out;
    r.sum_ok    = sum_ok;
    r.pattern   = kept_pattern;
    r.position  = kept_position;
    if (kept_pattern == PAT_CAN_RIGHT) r.direction = DIR_CAN_RIGHT;
    else if (kept_pattern == PAT_CAN_LEFT) r.direction = DIR_CAN_LEFT;
    else if (kept_pattern == PAT_BOTH) r.direction = DIR_BOTH;
    else r.direction = DIR_FORWARD;
    expected_readings.push_back(r);
  endtask

  task automatic send_pulse(input logic [PulseWidthW-1:0] w, input logic st);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(InDataW-PulseWidthW){1'b0}}, w};
    s_axis_tuser <= st;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    track_pulse(w, st);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    case (idx)
      CFG_SHORT_MIN: cfg_short_min = v;
      CFG_SHORT_MAX: cfg_short_max = v;
      CFG_OFF_LINE:  cfg_off_line = v;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_registers(input logic [CfgW-1:0] lo, input logic [CfgW-1:0] hi,
                               input logic [CfgW-1:0] off);
    write_reg(CFG_SHORT_MIN, lo);
    write_reg(CFG_SHORT_MAX, hi);
    write_reg(CFG_OFF_LINE, off);
    settings_used++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (IdleTail) @(posedge clk_i);
  endtask

  function automatic logic [PulseWidthW-1:0] lost_width();
    case ($urandom_range(0, 2))
      0: return '0;
      1: return PULSE_SATURATION;
      default: return PulseWidthW'($urandom_range(511, 256));
    endcase
  endfunction

  // a width that reads as the wanted bit without a timeout where possible
  function automatic logic [PulseWidthW-1:0] pick_width(input logic b);
    int lo;
    int hi;
    lo = cfg_short_min;
    hi = cfg_short_max;
    if (!b && hi - lo >= 2) return PulseWidthW'($urandom_range(hi - 1, lo + 1));
    if (lo >= 1 && (hi > 254 || $urandom_range(0, 1) == 0))
      return PulseWidthW'($urandom_range(lo, 1));
    if (hi <= 254) return PulseWidthW'($urandom_range(254, hi));
    return lost_width();
  endfunction

  task automatic send_frame(input logic [PatternW-1:0] pat, input bit bad_sum,
                            input int lost_at);
    logic [FrameLen-1:0]    word;
    logic [PulseWidthW-1:0] w;
    int                     k;
    word = {2'($urandom), pat, 2'($urandom), ~pat};
    if (bad_sum) begin
      k = $urandom_range(0, 5);
      word[k] = ~word[k];
    end
    for (int i = 0; i < FrameLen; i++) begin
      w = (i == lost_at) ? lost_width() : pick_width(word[FrameLen-1-i]);
      send_pulse(w, i == 0);
    end
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) begin
      send_pulse(PulseWidthW'($urandom), $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic test_reset_state();
    send_pulse(9'd70, 1'b0);
    send_pulse(9'd300, 1'b0);
    send_pulse(9'd0, 1'b0);
    send_frame(6'b000111, 1'b1, -1);
    wait_idle();
  endtask

  task automatic test_steering_patterns();
    send_frame(PAT_CAN_RIGHT, 1'b0, -1);
    send_frame(PAT_CAN_LEFT, 1'b0, -1);
    send_frame(PAT_BOTH, 1'b0, -1);
    send_frame(6'b000000, 1'b0, -1);
    send_frame(6'b100001, 1'b0, -1);
    send_frame(6'b000001, 1'b0, -1);
    wait_idle();
  endtask

  task automatic test_lost_pulses();
    send_frame(6'b011100, 1'b0, 0);
    send_frame(6'b011100, 1'b0, 15);
    send_pulse(9'd511, 1'b1);
    for (int i = 1; i < FrameLen; i++) send_pulse(9'd255, 1'b0);
    wait_idle();
  endtask

  task automatic test_frame_restart();
    send_pulse(9'd75, 1'b1);
    send_pulse(9'd150, 1'b0);
    send_pulse(9'd20, 1'b0);
    send_frame(6'b110000, 1'b0, -1);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    set_registers(8'd0, 8'd255, 8'h80);
    send_frame(6'b000000, 1'b0, -1);
    wait_idle();
    set_registers(8'd255, 8'd0, 8'h80);
    send_frame(6'b010101, 1'b0, -1);
    wait_idle();
    set_registers(8'd253, 8'd255, 8'h80);
    send_frame(6'b000000, 1'b0, -1);
    send_frame(6'b001100, 1'b0, -1);
    wait_idle();
    // new off-line code must not touch the kept position
    set_registers(SHORT_MIN_RST, SHORT_MAX_RST, 8'h7F);
    send_frame(6'b000000, 1'b1, -1);
    send_frame(6'b101000, 1'b0, -1);
    wait_idle();
  endtask

  task automatic test_random_frames();
    logic [PatternW-1:0] pat;
    logic [CfgW-1:0]     lo;
    logic [CfgW-1:0]     hi;
    int                  goal;
    goal = decoded_pulses + RandomItems;
    while (decoded_pulses < goal) begin
      case ($urandom_range(0, 7))
        0: begin
          lo = 8'd0;
          hi = 8'd255;
        end
        1: begin
          lo = 8'($urandom);
          hi = 8'($urandom_range(lo + 1, 0));
        end
        2: begin
          lo = 8'($urandom_range(255, 240));
          hi = 8'd255;
        end
        default: begin
          lo = 8'($urandom_range(200, 0));
          hi = 8'(lo + $urandom_range(55, 2));
        end
      endcase
      set_registers(lo, hi, 8'($urandom));
      for (int f = 0; f < 6; f++) begin
        case ($urandom_range(0, 4))
          0: pat = PAT_CAN_RIGHT;
          1: pat = PAT_CAN_LEFT;
          2: pat = PAT_BOTH;
          default: pat = PatternW'($urandom);
        endcase
        case ($urandom_range(0, 9))
          0: send_frame(pat, 1'b1, -1);
          1: send_frame(pat, 1'b0, $urandom_range(0, FrameLen - 1));
          2: begin
            send_pulse(pick_width(1'($urandom_range(0, 1))), 1'b1);
            send_noise($urandom_range(0, 10));
            send_frame(pat, 1'b0, -1);
          end
          3: send_noise($urandom_range(1, 20));
          default: send_frame(pat, 1'b0, -1);
        endcase
      end
      wait_idle();
    end
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    rx_tick++;
    if (rx_tick % 128 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= (rx_tick % 3 == 0);
      2: m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= (rx_tick % 16) < 11;
    endcase
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_reading
    reading_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: result item with none expected, actual %h", $time, m_axis_tdata);
        error_count++;
      end else begin
        want = expected_readings.pop_front();
        check_field("reading_valid", want.rd_valid, m_axis_tdata[0]);
        check_field("timed_out", want.timed_out, m_axis_tdata[1]);
        check_field("checksum_ok", want.sum_ok, m_axis_tdata[2]);
        check_field("pattern", want.pattern, m_axis_tdata[8:3]);
        check_field("position", want.position, $signed(m_axis_tdata[16:9]));
        check_field("direction", want.direction, m_axis_tdata[18:17]);
        readings_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no item moved for %0d cycles", $time, QuietLimit);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_steering_patterns();
    test_lost_pulses();
    test_frame_restart();
    test_register_extremes();
    test_random_frames();
    wait_idle();
    if (expected_readings.size() != 0) begin
      $display("%0t: %0d readings never arrived", $time, expected_readings.size());
      error_count++;
    end
    $display("decoded %0d pulse items into %0d checked readings", decoded_pulses,
             readings_checked);
    $display("over %0d register settings, with lost pulses, bad checksums and restarts",
             settings_used);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pwlsd_pkg.sv
hdl/pwlsd_ctrl.sv
hdl/pwlsd_dp.sv
hdl/pulse_width_line_sensor_decoder_unit.sv
tb/pulse_width_line_sensor_decoder_unit_test.sv
